>>> src/mmaq_pkg.sv
// Shared types and constants for the min/max affine uint8 quantizer.
package mmaq_pkg;

  localparam logic [1:0] OP_OBSERVE = 2'd0;
  localparam logic [1:0] OP_FINISH  = 2'd1;
  localparam logic [1:0] OP_QUANT   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;

  localparam logic RK_PARAMS = 1'b0;
  localparam logic RK_CODE   = 1'b1;

  localparam int RECIP_W    = 41;
  localparam int RECIP_LO_W = 21;
  localparam int RECIP_HI_W = RECIP_W - RECIP_LO_W;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] sample;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  code;
    logic [7:0]  zp_value;
    logic [31:0] value_range;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [1:0] {
    WK_OBSERVE,
    WK_FINISH,
    WK_QUANT
  } work_kind_t;

  typedef struct packed {
    work_kind_t  kind;
    logic [31:0] sample;
  } work_item_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_SETUP,
    FS_ZP_LAUNCH,
    FS_ZP_WAIT,
    FS_RC_LAUNCH,
    FS_RC_WAIT,
    FS_REPORT
  } fin_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> src/mmaq_fifo.sv
// Small register FIFO used between the front and back and on the result side.
module mmaq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == (AW+1)'(DEPTH);
  assign empty   = count == '0;
  assign rdata   = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointers wrap at DEPTH, so any depth of two or more works
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wdata;
  end

endmodule

>>> src/mmaq_front.sv
// Front stage: accepts transactions, decodes the operation and drops unused codes.
module mmaq_front
  import mmaq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  in_item_t   item,
  output logic       full,
  output logic       q_push,
  output work_item_t q_data,
  input  logic       q_full
);

  logic       valid;
  work_item_t held;
  logic       keep;
  work_kind_t kind;
  logic       take;

  always_comb begin
    keep = 1'b1;
    kind = WK_OBSERVE;
    unique case (item.operation)
      OP_OBSERVE: kind = WK_OBSERVE;
      OP_FINISH:  kind = WK_FINISH;
      OP_QUANT:   kind = WK_QUANT;
      default:    keep = 1'b0;
    endcase
  end

  assign q_push = valid && !q_full;
  assign q_data = held;
  assign full   = valid && q_full;
  assign take   = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= keep;
    end else if (q_push) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held.kind   <= kind;
      held.sample <= $unsigned(item.sample);
    end
  end

endmodule

>>> src/mmaq_div.sv
// Restoring divider, one quotient bit per cycle.
module mmaq_div
  import mmaq_pkg::*;
#(
  parameter int NUM_W = 42,
  parameter int DEN_W = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output div_stat_t        stat,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CW-1:0]    left;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial     = {rem, num_sh[NUM_W-1]};
  assign diff      = trial - {1'b0, den};
  assign fits      = !diff[DEN_W];
  assign stat.busy = busy;
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        left <= CW'(NUM_W);
      end else if (busy) begin
        left <= left - 1'b1;
        if (left == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= numer;
      den    <= denom;
      rem    <= '0;
      quo    <= '0;
    end else if (busy) begin
      num_sh <= num_sh << 1;
      rem    <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo    <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

>>> src/mmaq_back.sv
// Back end: min/max tracking, finish sequencer and the quantize pipeline.
module mmaq_back
  import mmaq_pkg::*;
#(
  parameter int SAMPLE_BITS = 32,
  parameter int NUM_W       = 42
) (
  input  logic                   clk,
  input  logic                   rst,
  input  work_item_t             q_data,
  input  logic                   q_empty,
  output logic                   q_pop,
  output logic                   out_push,
  output out_item_t              out_data,
  input  logic                   out_full,
  output logic                   div_start,
  output logic [NUM_W-1:0]       div_numer,
  output logic [SAMPLE_BITS:0]   div_denom,
  input  div_stat_t              div_stat,
  input  logic [NUM_W-1:0]       div_quo
);

  localparam int SB   = SAMPLE_BITS;
  localparam int PLW  = SB + RECIP_LO_W + 1;
  localparam int PHW  = SB + RECIP_HI_W + 1;
  localparam int SUMW = SB + RECIP_W + 1;
  localparam int QW   = SUMW - 32;
  localparam int CLW  = QW + 1;
  localparam int MW   = SB + 10;
  localparam logic signed [SB-1:0] MIN_INIT = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] MAX_INIT = {1'b1, {(SB-1){1'b0}}};
  localparam logic [NUM_W-1:0]     RC_BASE  = NUM_W'(255) << 33;
  localparam logic [SUMW-1:0]      HALF     = SUMW'(1) << 31;

  fin_state_t state;
  fin_state_t state_next;

  logic signed [SB-1:0] min_seen;
  logic signed [SB-1:0] max_seen;
  logic                 any_seen;
  logic [7:0]           zp_reg;
  logic [RECIP_W-1:0]   recip_reg;
  logic [SB-1:0]        range_reg;
  logic [1:0]           param_status;
  logic [SB+8:0]        nm510;

  logic                 s1v, s2v, s3v;
  logic signed [PLW-1:0] s1_p_lo;
  logic signed [PHW-1:0] s1_p_hi;
  logic signed [QW-1:0]  s2_q;
  logic [7:0]            s3_code;

  logic [SB+31:0]        x_wide;
  logic signed [SB-1:0]  x;
  logic signed [PLW-1:0] p_lo_mul;
  logic signed [PHW-1:0] p_hi_mul;
  logic signed [SUMW-1:0] sum_c;
  logic signed [CLW-1:0] c_sum;
  logic [7:0]            code_next;
  logic                  params_ok;
  logic [SB:0]           range_diff;
  logic [SB-1:0]         range_now;
  logic signed [MW-1:0]  m_ext;
  logic signed [MW-1:0]  nm_full;
  logic [SB+31:0]        range_wide;

  logic pipe_empty, advance, head, do_obs, do_quant, do_fin, report;

  // Sample is the low SAMPLE_BITS of the zero-extended field, sign-extended.
  assign x_wide = {{SB{1'b0}}, q_data.sample};
  assign x      = $signed(x_wide[SB-1:0]);

  assign pipe_empty = !s1v && !s2v && !s3v;
  assign advance    = !s3v || !out_full;
  assign head       = !q_empty && (state == FS_IDLE);
  assign do_obs     = head && (q_data.kind == WK_OBSERVE);
  assign do_quant   = head && (q_data.kind == WK_QUANT) && advance;
  assign do_fin     = head && (q_data.kind == WK_FINISH) && pipe_empty;
  assign q_pop      = do_obs || do_quant || do_fin;

  assign range_diff = {max_seen[SB-1], max_seen} - {min_seen[SB-1], min_seen};
  assign range_now  = range_diff[SB-1:0];
  // 2*255*(-min) for a negative minimum
  assign m_ext      = MW'(min_seen);
  assign nm_full    = (m_ext <<< 1) - (m_ext <<< 9);

  // Quantize datapath
  assign p_lo_mul  = x * $signed({1'b0, recip_reg[RECIP_LO_W-1:0]});
  assign p_hi_mul  = x * $signed({1'b0, recip_reg[RECIP_W-1:RECIP_LO_W]});
  assign sum_c     = (SUMW'(s1_p_hi) <<< RECIP_LO_W) + SUMW'(s1_p_lo) + $signed(HALF);
  assign c_sum     = CLW'(s2_q) + CLW'($signed({1'b0, zp_reg}));
  assign params_ok = (param_status == ST_OK) && (recip_reg != '0);

  always_comb begin
    if (!params_ok || c_sum[CLW-1]) begin
      code_next = 8'd0;
    end else if (|c_sum[CLW-2:8]) begin
      code_next = 8'hFF;
    end else begin
      code_next = c_sum[7:0];
    end
  end

  // Finish sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      FS_IDLE:      if (do_fin) state_next = FS_SETUP;
      FS_SETUP: begin
        if (!any_seen || range_now == '0) state_next = FS_REPORT;
        else                              state_next = FS_ZP_LAUNCH;
      end
      FS_ZP_LAUNCH: state_next = FS_ZP_WAIT;
      FS_ZP_WAIT:   if (div_stat.done) state_next = FS_RC_LAUNCH;
      FS_RC_LAUNCH: state_next = FS_RC_WAIT;
      FS_RC_WAIT:   if (div_stat.done) state_next = FS_REPORT;
      FS_REPORT:    if (!out_full) state_next = FS_IDLE;
      default:      state_next = FS_IDLE;
    endcase
  end

  // Finish sequencer: outputs
  always_comb begin
    div_start = 1'b0;
    report    = 1'b0;
    div_numer = RC_BASE + NUM_W'(range_reg);
    div_denom = {range_reg, 1'b0};
    unique case (state)
      FS_ZP_LAUNCH: begin
        div_start = 1'b1;
        div_numer = NUM_W'(nm510) + NUM_W'(range_reg);
      end
      FS_RC_LAUNCH: div_start = 1'b1;
      FS_REPORT:    report    = 1'b1;
      default:      ;
    endcase
  end

  assign range_wide = {32'b0, range_reg};
  assign out_push   = (s3v || report) && !out_full;

  always_comb begin
    out_data.result_kind = report ? RK_PARAMS : RK_CODE;
    out_data.code        = report ? 8'd0 : s3_code;
    out_data.zp_value    = zp_reg;
    out_data.value_range = range_wide[31:0];
    out_data.status      = param_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= FS_IDLE;
      min_seen     <= MIN_INIT;
      max_seen     <= MAX_INIT;
      any_seen     <= 1'b0;
      zp_reg       <= '0;
      recip_reg    <= '0;
      range_reg    <= '0;
      param_status <= ST_EMPTY;
      s1v          <= 1'b0;
      s2v          <= 1'b0;
      s3v          <= 1'b0;
    end else begin
      state <= state_next;
      if (do_obs) begin
        if (x < min_seen) min_seen <= x;
        if (x > max_seen) max_seen <= x;
        any_seen <= 1'b1;
      end
      if (state == FS_SETUP) begin
        zp_reg    <= '0;
        recip_reg <= '0;
        range_reg <= '0;
        if (!any_seen)             param_status <= ST_EMPTY;
        else if (range_now == '0) param_status <= ST_ZERO;
        else                       range_reg    <= range_now;
      end
      if (state == FS_ZP_WAIT && div_stat.done) begin
        zp_reg <= (|div_quo[NUM_W-1:8]) ? 8'hFF : div_quo[7:0];
      end
      if (state == FS_RC_WAIT && div_stat.done) begin
        recip_reg    <= div_quo[RECIP_W-1:0];
        param_status <= ST_OK;
      end
      if (advance) begin
        s1v <= do_quant;
        s2v <= s1v;
        s3v <= s2v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == FS_SETUP) nm510 <= min_seen[SB-1] ? nm_full[SB+8:0] : '0;
    if (advance) begin
      s1_p_lo <= p_lo_mul;
      s1_p_hi <= p_hi_mul;
      s2_q    <= sum_c[SUMW-1:32];
      s3_code <= code_next;
    end
  end

endmodule

>>> src/minmax_affine_uint8_quantizer.sv
// Top level of the min/max affine uint8 quantizer.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------
//   item    | in        | push / full         | in_item_t  (operation, sample)
//   result  | out       | pop / empty         | out_item_t (kind, code, zp,
//           |           |                     |  value_range, status)
//
// Observe and quantize transactions issue one per cycle from the work queue;
// while no finish runs, a quantize only while its pipe is not stalled; a
// quantize result passes the front register, the work queue and the
// three-stage multiply/round/clamp pipe. A finish waits for the quantize
// pipe to drain, then, unless no samples were seen or the range is zero,
// runs the shared bit-serial divider twice (zero point, then reciprocal)
// before its report enters the result queue; NUM_W = max(SAMPLE_BITS+9, 42).
// Synchronous active-high reset restores the calibration state (status says
// no samples observed) and empties both queues.
// A full result queue stalls the quantize pipe and the finish report; the
// front takes transactions until the work queue and its register are full.
module minmax_affine_uint8_quantizer
  import mmaq_pkg::*;
#(
  parameter int SAMPLE_BITS = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  in_item_t  item,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  localparam int NUM_W  = (SAMPLE_BITS + 9 > 42) ? SAMPLE_BITS + 9 : 42;
  localparam int DEN_W  = SAMPLE_BITS + 1;
  localparam int WORK_W = $bits(work_item_t);
  localparam int OUT_W  = $bits(out_item_t);

  // front -> work queue
  logic             mid_push;
  logic             mid_full;
  work_item_t       mid_wdata;
  logic [WORK_W-1:0] mid_rdata;
  logic             mid_empty;
  logic             mid_pop;
  work_item_t       mid_head;

  // back -> result queue
  logic             out_push;
  logic             out_full;
  out_item_t        out_wdata;
  logic [OUT_W-1:0] out_rdata;

  // back <-> divider
  logic             div_start;
  logic [NUM_W-1:0] div_numer;
  logic [DEN_W-1:0] div_denom;
  div_stat_t        div_stat;
  logic [NUM_W-1:0] div_quo;

  assign mid_head = work_item_t'(mid_rdata);
  assign result   = out_item_t'(out_rdata);

  mmaq_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .q_push (mid_push),
    .q_data (mid_wdata),
    .q_full (mid_full)
  );

  mmaq_fifo #(
    .WIDTH (WORK_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_work_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  mmaq_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .NUM_W       (NUM_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (mid_head),
    .q_empty   (mid_empty),
    .q_pop     (mid_pop),
    .out_push  (out_push),
    .out_data  (out_wdata),
    .out_full  (out_full),
    .div_start (div_start),
    .div_numer (div_numer),
    .div_denom (div_denom),
    .div_stat  (div_stat),
    .div_quo   (div_quo)
  );

  mmaq_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  mmaq_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  // The back end must never drop a result into a full queue.
  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("result pushed into full queue");

  // The front must hold its item while the work queue is full.
  a_mid_no_overflow: assert property (@(posedge clk) disable iff (rst)
    mid_push |-> !mid_full)
    else $error("work item pushed into full queue");

  // The divider is launched only when idle, and then runs.
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider launched while busy");

  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    div_start |=> div_stat.busy)
    else $error("divider did not start");

endmodule
